### design/tvsng_pkg.sv
// Package for the two-voice square/noise sound generator.
// Holds field widths, register and operation codes, the volume table function
// and the constant noise sequence. No dependencies.
package tvsng_pkg;

  parameter int FRAC_BITS_DEF = 4;
  localparam int NOISE_LEN = 256;
  localparam int NOISE_IDX_W = $clog2(NOISE_LEN);
  localparam int STEP_W = 10;
  localparam int FREQ_W = 10;
  localparam int LVL_W = 14;
  localparam int SMP_W = 15;
  localparam logic [STEP_W-1:0] OSC_STEP_RST = 10'd40;
  localparam logic [FREQ_W-1:0] FREQ_HOLD = 10'h3FE;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_V1_LO = 3'd0,
    REG_V2_LO = 3'd1,
    REG_V2_HI = 3'd2,
    REG_CTRL  = 3'd3,
    REG_V1_HI = 3'd4
  } reg_addr_t;

  // Per-voice commands from the top level
  typedef struct packed {
    logic wr_lo;
    logic wr_hi;
    logic load;
    logic tick;
  } voice_ctl_t;

  // Per-voice status back to the top level
  typedef struct packed {
    logic wrapped;
    logic hold_set;
  } voice_sts_t;

  // idx[3:0] volume, idx[5:4] voice bits; both voice bits set doubles the level
  function automatic logic [LVL_W-1:0] vol_lookup(input logic [5:0] idx);
    logic [3:0]       lo;
    logic [2:0]       lo_m1;
    logic [LVL_W-1:0] v;
    lo = idx[3:0];
    if (lo > 4'd8) begin
      lo = 4'd8;
    end
    lo_m1 = 3'(lo - 4'd1);
    v = LVL_W'(586) + LVL_W'({lo_m1, 10'd0});
    if (idx[3:0] == 4'd0 || idx[5:4] == 2'b00) begin
      v = '0;
    end else if (idx[5:4] == 2'b11) begin
      v = {v[LVL_W-2:0], 1'b0};
    end
    return v;
  endfunction

  // 8-bit LFSR seeded 0xa8, one output bit per step
  function automatic logic [NOISE_LEN-1:0] noise_gen();
    logic [7:0]           lfsr;
    logic                 fb;
    logic [NOISE_LEN-1:0] tab;
    lfsr = 8'hA8;
    tab = '0;
    for (int i = 0; i < NOISE_LEN; i++) begin
      tab[i] = lfsr[0];
      fb = 1'b1 ^ lfsr[7] ^ lfsr[5] ^ lfsr[4] ^ lfsr[1];
      lfsr = {lfsr[6:0], fb};
    end
    return tab;
  endfunction

  localparam logic [NOISE_LEN-1:0] NOISE_TAB = noise_gen();

endpackage

### design/tvsng_if.sv
// Handshake channels of the sound generator: item input, sample output, config.
// Depends on tvsng_pkg.
interface tvsng_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [2:0]                    reg_addr;
  logic [7:0]                    wr_data;
  modport source (output valid, output op, output reg_addr, output wr_data, input ready);
  modport sink   (input valid, input op, input reg_addr, input wr_data, output ready);
endinterface

interface tvsng_out_if;
  logic                          valid;
  logic                          ready;
  logic [tvsng_pkg::SMP_W-1:0]   sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tvsng_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tvsng_pkg::STEP_W-1:0]  osc_step;
  modport source (output valid, output osc_step, input ready);
  modport sink   (input valid, input osc_step, output ready);
endinterface

### design/tvsng_voice.sv
// One voice oscillator: frequency, reload and saturating counter.
// Depends on tvsng_pkg.
module tvsng_voice #(
  parameter int FRAC_BITS = tvsng_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tvsng_pkg::STEP_W-1:0]  step,
  input  logic [7:0]                    wr_data,
  input  tvsng_pkg::voice_ctl_t         ctl,
  output tvsng_pkg::voice_sts_t         sts
);
  import tvsng_pkg::*;

  localparam int CNT_W = FRAC_BITS + 13;
  localparam int SUM_W = CNT_W + 1;
  localparam int RLD_W = FRAC_BITS + FREQ_W;
  localparam logic [RLD_W-1:0] WRAP_RLD = RLD_W'(10'h3FF) << FRAC_BITS;
  localparam logic [SUM_W-1:0] WRAP_SUM = SUM_W'(WRAP_RLD);
  localparam logic [SUM_W-1:0] CNT_MAX = SUM_W'((64'd1 << CNT_W) - 64'd1);

  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [RLD_W-1:0]  reload_r, reload_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum1, sum2;
  logic              hit;

  always_comb begin
    freq_nxt = freq_r;
    if (ctl.wr_lo) begin
      freq_nxt = {freq_r[9:8], wr_data};
    end else if (ctl.wr_hi) begin
      freq_nxt = {wr_data[1:0], freq_r[7:0]};
    end
    reload_nxt = reload_r;
    if (ctl.wr_lo || ctl.wr_hi) begin
      reload_nxt = RLD_W'(freq_nxt + FREQ_W'(1)) << FRAC_BITS;
    end
  end

  // advance, saturate, then fold past the wrap point onto the reload
  always_comb begin
    sum1 = SUM_W'(cnt_r) + SUM_W'(step);
    if (sum1 > CNT_MAX) begin
      sum1 = CNT_MAX;
    end
    hit = (sum1 >= WRAP_SUM);
    sum2 = SUM_W'(reload_r) + (sum1 - WRAP_SUM);
    if (sum2 > CNT_MAX) begin
      sum2 = CNT_MAX;
    end
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      cnt_nxt = CNT_W'(reload_r);
    end else if (ctl.tick) begin
      cnt_nxt = hit ? CNT_W'(sum2) : CNT_W'(sum1);
    end
  end

  assign sts.wrapped  = ctl.tick && hit && (reload_r != WRAP_RLD);
  assign sts.hold_set = (ctl.wr_lo || ctl.wr_hi) && (freq_nxt == FREQ_HOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r   <= '0;
      reload_r <= '0;
      cnt_r    <= '0;
    end else begin
      freq_r   <= freq_nxt;
      reload_r <= reload_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### design/two_voice_square_noise_sound_generator_core.sv
// Top level of the two-voice square/noise sound generator.
// Depends on tvsng_pkg, tvsng_if and tvsng_voice.
//
//   channel  dir  payload                    handshake
//   in_ch    in   op, reg_addr, wr_data      valid/ready
//   out_ch   out  sample (15 bit)            valid/ready
//   cfg_ch   in   osc_step (10 bit)          valid/ready, ready always high
//
// One item per cycle sustained unless a tick waits on a stalled out_ch. An item
// is processed while it sits in the input register, and a tick's sample goes
// into the output register as it is processed. Register writes give no sample.
// Reset is synchronous (rst_n low); valid flags and sound state clear, osc_step
// returns to 40; payload and sample registers keep their value. A stalled out_ch
// stops ticks only once the output register is full; writes still drain past it.
module two_voice_square_noise_sound_generator_core #(
  parameter int FRAC_BITS = tvsng_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tvsng_in_if.sink    in_ch,
  tvsng_out_if.source out_ch,
  tvsng_cfg_if.sink   cfg_ch
);
  import tvsng_pkg::*;

  logic              s1_valid_r;
  logic              s1_op_r;
  logic [2:0]        s1_addr_r;
  logic [7:0]        s1_data_r;
  logic              s1_go;
  logic              s1_tick;

  logic [STEP_W-1:0] osc_step_r;
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [1:0]        toggle_r, toggle_nxt;
  logic [NOISE_IDX_W-1:0] idx_r, idx_nxt;
  logic [LVL_W-1:0]  lvl0_r, lvl0_nxt, lvl1_r, lvl1_nxt, digi_r, digi_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0]  sample_r, sample_nxt;

  voice_ctl_t        ctl0, ctl1;
  voice_sts_t        sts0, sts1;
  logic              ns_cur, ns_new;

  assign s1_tick     = (op_t'(s1_op_r) == OP_TICK);
  assign s1_go       = s1_valid_r && (!s1_tick || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign cfg_ch.ready = 1'b1;

  tvsng_voice #(.FRAC_BITS(FRAC_BITS)) u_voice0 (
    .clk(clk), .rst_n(rst_n), .step(osc_step_r), .wr_data(s1_data_r),
    .ctl(ctl0), .sts(sts0)
  );

  tvsng_voice #(.FRAC_BITS(FRAC_BITS)) u_voice1 (
    .clk(clk), .rst_n(rst_n), .step(osc_step_r), .wr_data(s1_data_r),
    .ctl(ctl1), .sts(sts1)
  );

  // voice command decode
  always_comb begin
    ctl0 = '0;
    ctl1 = '0;
    if (s1_go && !s1_tick) begin
      case (reg_addr_t'(s1_addr_r))
        REG_V1_LO: ctl0.wr_lo = 1'b1;
        REG_V1_HI: ctl0.wr_hi = 1'b1;
        REG_V2_LO: ctl1.wr_lo = 1'b1;
        REG_V2_HI: ctl1.wr_hi = 1'b1;
        REG_CTRL: begin
          ctl0.load = s1_data_r[7];
          ctl1.load = s1_data_r[7];
        end
        default: ;
      endcase
    end else if (s1_go && !ctrl_r[7]) begin
      ctl0.tick = 1'b1;
      ctl1.tick = 1'b1;
    end
  end

  // noise gates voice 2 only while voice 2 is disabled
  assign ns_cur = ctrl_r[6] & ~ctrl_r[5];
  assign ns_new = s1_data_r[6] & ~s1_data_r[5];

  always_comb begin
    ctrl_nxt   = ctrl_r;
    toggle_nxt = toggle_r;
    idx_nxt    = idx_r;
    lvl0_nxt   = lvl0_r;
    lvl1_nxt   = lvl1_r;
    digi_nxt   = digi_r;
    if (s1_go && !s1_tick) begin
      if (sts0.hold_set) begin
        toggle_nxt[0] = 1'b1;
        lvl0_nxt = vol_lookup({1'b0, ctrl_r[4], ctrl_r[3:0]});
      end
      if (sts1.hold_set) begin
        toggle_nxt[1] = 1'b1;
        lvl1_nxt = vol_lookup({ctrl_r[5], ns_cur, ctrl_r[3:0]});
      end
      if (reg_addr_t'(s1_addr_r) == REG_CTRL) begin
        if (s1_data_r[7]) begin
          toggle_nxt = 2'b11;
          idx_nxt    = '1;
          digi_nxt   = vol_lookup(s1_data_r[5:0]);
        end
        ctrl_nxt = s1_data_r;
        lvl0_nxt = vol_lookup({1'b0, toggle_nxt[0] & s1_data_r[4], s1_data_r[3:0]});
        lvl1_nxt = vol_lookup({(toggle_nxt[1] & s1_data_r[5]) |
                               (NOISE_TAB[idx_nxt] & ns_new), 1'b0, s1_data_r[3:0]});
      end
    end else if (s1_go && !ctrl_r[7]) begin
      if (sts0.wrapped) begin
        toggle_nxt[0] = ~toggle_r[0];
        lvl0_nxt = vol_lookup({1'b0, toggle_nxt[0] & ctrl_r[4], ctrl_r[3:0]});
      end
      if (sts1.wrapped) begin
        toggle_nxt[1] = ~toggle_r[1];
        idx_nxt = idx_r + NOISE_IDX_W'(1);
        lvl1_nxt = vol_lookup({(toggle_nxt[1] & ctrl_r[5]) |
                               (NOISE_TAB[idx_nxt] & ns_cur), 1'b0, ctrl_r[3:0]});
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    sample_nxt    = sample_r;
    if (s1_go && s1_tick) begin
      out_valid_nxt = 1'b1;
      sample_nxt = ctrl_r[7] ? SMP_W'(digi_r) : (SMP_W'(lvl0_nxt) + SMP_W'(lvl1_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      osc_step_r  <= OSC_STEP_RST;
      ctrl_r      <= '0;
      toggle_r    <= '0;
      idx_r       <= '0;
      lvl0_r      <= '0;
      lvl1_r      <= '0;
      digi_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        osc_step_r <= cfg_ch.osc_step;
      end
      ctrl_r   <= ctrl_nxt;
      toggle_r <= toggle_nxt;
      idx_r    <= idx_nxt;
      lvl0_r   <= lvl0_nxt;
      lvl1_r   <= lvl1_nxt;
      digi_r   <= digi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r   <= in_ch.op;
      s1_addr_r <= in_ch.reg_addr;
      s1_data_r <= in_ch.wr_data;
    end
    sample_r <= sample_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = sample_r;

endmodule

### design/tvsng_checker.sv
// Port-level checks for the sound generator, bound to its top level.
// Depends on tvsng_pkg and two_voice_square_noise_sound_generator_core.
module tvsng_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tvsng_pkg::SMP_W-1:0]  out_sample
);
  import tvsng_pkg::*;

  localparam logic [SMP_W-1:0] SMP_MAX = 15'd31016;

  // a held sample keeps valid and value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("output item changed while stalled");

  a_out_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample <= SMP_MAX)
    else $error("sample above mixer maximum");

  // every table level is even, so every mix is even
  a_out_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_sample[0])
    else $error("odd sample");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind two_voice_square_noise_sound_generator_core tvsng_checker u_tvsng_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample)
);

### tb/two_voice_square_noise_sound_generator_core_test.sv
// Self-checking testbench for the two-voice square/noise sound generator core.
// Predicts every rendered sample from register writes, ticks and osc_step.
// Depends on tvsng_pkg, tvsng_if and the core.
module two_voice_square_noise_sound_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tvsng_pkg::*;

  localparam int FRAC = 4;
  localparam int unsigned WRAP_POINT = 32'h3FF << FRAC;
  localparam int unsigned COUNT_TOP = (32'd1 << (FRAC + 13)) - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 4;
  localparam int V1_EN_BIT = 4;
  localparam int V2_EN_BIT = 5;
  localparam int NOISE_BIT = 6;
  localparam int DIGI_BIT = 7;
  localparam logic [7:0] CTRL_OFF = 8'h00;
  localparam logic [7:0] CTRL_BOTH_FULL = 8'h3F;
  localparam logic [7:0] CTRL_NOISE_V8 = 8'h48;
  localparam logic [7:0] CTRL_V1_ONLY = 8'h1F;
  localparam logic [7:0] CTRL_DIGI_FULL = 8'hBF;
  localparam logic [7:0] CTRL_DIGI_MUTE = 8'h80;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  tvsng_in_if  in_ch();
  tvsng_out_if out_ch();
  tvsng_cfg_if cfg_ch();

  two_voice_square_noise_sound_generator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Sound state mirror
  bit [255:0]   noise_seq;
  logic [9:0]   step_cfg;
  logic [9:0]   freq [2];
  int unsigned  reload [2];
  int unsigned  counter [2];
  logic [1:0]   flipflops;
  logic [7:0]   noise_pos;
  logic [7:0]   ctrl;
  logic [13:0]  level [2];
  logic [13:0]  digi_lvl;
  logic [14:0]  expected_samples [$];

  int         errors;
  int         cycles;
  int         sink_stall;
  idle_mode_t send_mode;
  idle_mode_t sink_mode;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default:   return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [13:0] volume_level(logic [5:0] idx);
    int lo;
    int v;
    lo = idx[3:0];
    if (lo == 0 || idx[5:4] == 2'b00) return '0;
    if (lo > 8) lo = 8;
    v = 586 + (lo - 1) * 1024;
    if (idx[5:4] == 2'b11) v = v * 2;
    return 14'(v);
  endfunction

  // noise reaches voice 2 only while voice 2 itself is disabled
  function automatic logic noise_gate();
    return ctrl[NOISE_BIT] & ~ctrl[V2_EN_BIT];
  endfunction

  function automatic logic [13:0] voice1_level();
    return volume_level({1'b0, flipflops[0] & ctrl[V1_EN_BIT], ctrl[3:0]});
  endfunction

  function automatic logic [13:0] voice2_level();
    return volume_level({(flipflops[1] & ctrl[V2_EN_BIT]) | (noise_seq[noise_pos] & noise_gate()),
                         1'b0, ctrl[3:0]});
  endfunction

  function automatic void reset_sound_state();
    logic [7:0] sr;
    logic       fb;
    sr = 8'hA8;
    for (int i = 0; i < 256; i++) begin
      noise_seq[i] = sr[0];
      fb = ~(sr[7] ^ sr[5] ^ sr[4] ^ sr[1]);
      sr = {sr[6:0], fb};
    end
    step_cfg = OSC_STEP_RST;
    for (int v = 0; v < 2; v++) begin
      freq[v] = '0;
      reload[v] = 0;
      counter[v] = 0;
      level[v] = '0;
    end
    flipflops = '0;
    noise_pos = '0;
    ctrl = '0;
    digi_lvl = '0;
  endfunction

  function automatic void load_freq(int v, logic [9:0] f);
    freq[v] = f;
    if (f == FREQ_HOLD) begin
      flipflops[v] = 1'b1;
      // hold level uses the enable bit directly, noise lands on bit 4 here
      if (v == 0) level[0] = volume_level({1'b0, ctrl[V1_EN_BIT], ctrl[3:0]});
      else level[1] = volume_level({ctrl[V2_EN_BIT], noise_gate(), ctrl[3:0]});
    end
    reload[v] = ((int'(f) + 1) & 'h3FF) << FRAC;
  endfunction

  function automatic bit voice_advance(int v);
    int unsigned c;
    bit          wrapped;
    wrapped = 1'b0;
    c = counter[v] + step_cfg;
    if (c > COUNT_TOP) c = COUNT_TOP;
    if (c >= WRAP_POINT) begin
      wrapped = (reload[v] != WRAP_POINT);
      c = reload[v] + (c - WRAP_POINT);
      if (c > COUNT_TOP) c = COUNT_TOP;
    end
    counter[v] = c;
    return wrapped;
  endfunction

  function automatic void predict_item(op_t op, logic [2:0] addr, logic [7:0] data);
    logic [14:0] mix;
    if (op == OP_WRITE) begin
      case (addr)
        REG_V1_LO: load_freq(0, {freq[0][9:8], data});
        REG_V2_LO: load_freq(1, {freq[1][9:8], data});
        REG_V2_HI: load_freq(1, {data[1:0], freq[1][7:0]});
        REG_V1_HI: load_freq(0, {data[1:0], freq[0][7:0]});
        REG_CTRL: begin
          if (data[DIGI_BIT]) begin
            flipflops = 2'b11;
            counter[0] = reload[0];
            counter[1] = reload[1];
            noise_pos = 8'hFF;
            digi_lvl = volume_level(data[5:0]);
          end
          ctrl = data;
          level[0] = voice1_level();
          level[1] = voice2_level();
        end
        default: ;
      endcase
    end else if (ctrl[DIGI_BIT]) begin
      expected_samples.push_back({1'b0, digi_lvl});
    end else begin
      if (voice_advance(0)) begin
        flipflops[0] = ~flipflops[0];
        level[0] = voice1_level();
      end
      if (voice_advance(1)) begin
        flipflops[1] = ~flipflops[1];
        noise_pos = noise_pos + 8'd1;
        level[1] = voice2_level();
      end
      mix = level[0] + level[1];
      expected_samples.push_back(mix);
    end
  endfunction

  task automatic send_item(op_t op, logic [2:0] addr, logic [7:0] data);
    int gap;
    gap = draw_wait(send_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.reg_addr = addr;
    in_ch.wr_data = data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(op, addr, data);
  endtask

  task automatic tick();
    send_item(OP_TICK, 3'($urandom), 8'($urandom));
  endtask

  task automatic write_reg(reg_addr_t addr, logic [7:0] data);
    send_item(OP_WRITE, addr, data);
  endtask

  // sender holds off until every sample is back and the pipe has emptied
  task automatic wait_for_samples();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_osc_step(logic [9:0] step);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.osc_step = step;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    step_cfg = step;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic test_reset_state();
    repeat (3) tick();
    send_item(OP_WRITE, 3'd5, 8'hFF);
    send_item(OP_WRITE, 3'd6, 8'h00);
    send_item(OP_WRITE, 3'd7, 8'hA5);
    tick();
  endtask

  task automatic test_register_writes();
    write_reg(REG_CTRL, CTRL_BOTH_FULL);
    write_reg(REG_V1_LO, 8'hFF);
    write_reg(REG_V1_HI, 8'hFF);
    tick();
    write_reg(REG_V2_LO, 8'hFE);
    write_reg(REG_V2_HI, 8'h03);
    tick();
    write_reg(REG_V1_LO, 8'hFE);
    write_reg(REG_V1_HI, 8'hFC);
    tick();
    write_reg(REG_CTRL, CTRL_NOISE_V8);
    tick();
    tick();
    write_reg(REG_CTRL, CTRL_OFF);
    tick();
    write_reg(REG_CTRL, CTRL_DIGI_FULL);
    tick();
    tick();
    write_reg(REG_CTRL, CTRL_DIGI_MUTE);
    tick();
    write_reg(REG_V2_LO, 8'h00);
    write_reg(REG_V2_HI, 8'h00);
    write_reg(REG_CTRL, CTRL_V1_ONLY);
    tick();
  endtask

  task automatic test_step_extremes();
    logic [9:0] steps [3];
    steps = '{10'd0, 10'd1023, 10'd1};
    foreach (steps[i]) begin
      wait_for_samples();
      write_osc_step(steps[i]);
      write_reg(REG_V1_LO, 8'($urandom));
      write_reg(REG_V1_HI, 8'h03);
      write_reg(REG_CTRL, CTRL_BOTH_FULL);
      repeat (10) tick();
    end
  endtask

  task automatic test_counter_saturation();
    wait_for_samples();
    write_osc_step(10'd1023);
    write_reg(REG_V1_LO, 8'hFE);
    write_reg(REG_V1_HI, 8'h03);
    write_reg(REG_V2_LO, 8'hFE);
    write_reg(REG_V2_HI, 8'h03);
    write_reg(REG_CTRL, CTRL_BOTH_FULL);
    repeat (140) tick();
    // reload close to the wrap point: the excess keeps growing until the counter saturates at the top
    write_reg(REG_V1_LO, 8'hC0);
    repeat (40) tick();
    write_reg(REG_CTRL, CTRL_DIGI_FULL);
    tick();
    write_reg(REG_CTRL, CTRL_BOTH_FULL);
    repeat (10) tick();
  endtask

  task automatic random_item(output bit counted);
    int         pick;
    logic [7:0] data;
    reg_addr_t  addr;
    pick = $urandom_range(0, 99);
    data = 8'($urandom);
    counted = 1'b1;
    if (pick < 65) begin
      tick();
    end else if (pick < 70) begin
      send_item(OP_WRITE, 3'($urandom_range(5, 7)), data);
      counted = 1'b0;
    end else if (pick < 80) begin
      if ($urandom_range(0, 5) != 0) data[DIGI_BIT] = 1'b0;
      write_reg(REG_CTRL, data);
    end else begin
      case ($urandom_range(0, 3))
        0: addr = REG_V1_LO;
        1: addr = REG_V2_LO;
        2: addr = REG_V1_HI;
        default: addr = REG_V2_HI;
      endcase
      // mostly high frequencies so the voices wrap often
      if (addr == REG_V1_HI || addr == REG_V2_HI) begin
        if ($urandom_range(0, 3) != 0) data[1:0] = 2'b11;
      end else if ($urandom_range(0, 7) == 0) begin
        data = 8'hFE;
      end
      write_reg(addr, data);
    end
  endtask

  task automatic test_random_traffic(int total);
    int         done;
    bit         counted;
    logic [9:0] step;
    for (int phase = 0; phase < 8; phase++) begin
      wait_for_samples();
      case (phase)
        0: step = 10'd1023;
        1: step = 10'd1;
        2: step = 10'd0;
        default: step = 10'($urandom_range(100, 1023));
      endcase
      write_osc_step(step);
      send_mode = idle_mode_t'(phase % 3);
      sink_mode = idle_mode_t'((phase + 1) % 3);
      done = 0;
      while (done < total / 8) begin
        random_item(counted);
        if (counted) done++;
        if ($urandom_range(0, 199) == 0) wait_for_samples();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d", $time, out_ch.sample);
        errors++;
      end else if (out_ch.sample !== expected_samples[0]) begin
        $display("%0t: sample mismatch, expected %0d, actual %0d", $time,
                 expected_samples[0], out_ch.sample);
        errors++;
        void'(expected_samples.pop_front());
      end else begin
        void'(expected_samples.pop_front());
      end
      sink_stall = draw_wait(sink_mode);
    end
  end

  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_ch.ready = 1'b0;
      sink_stall--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles,
               expected_samples.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE;
    in_ch.reg_addr = '0;
    in_ch.wr_data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.osc_step = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    cycles = 0;
    sink_stall = 0;
    send_mode = IDLE_NONE;
    sink_mode = IDLE_NONE;
    reset_sound_state();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    send_mode = IDLE_SOME;
    sink_mode = IDLE_SOME;
    test_register_writes();
    test_step_extremes();
    sink_mode = IDLE_HEAVY;
    test_counter_saturation();
    test_random_traffic(1300);

    wait_for_samples();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
